@@ rtl/rdsb_pkg.sv @@
// Shared types, constants and digit helpers for the radix digit string converter.
`timescale 1ns / 1ps

package rdsb_pkg;

  // Limb geometry
  localparam int LimbCountDefault = 16;
  localparam int LimbBits         = 16;
  localparam int MaxResults       = 16;

  // Queue between front and back (depth is a power of two so pointers wrap)
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Radix codes
  localparam logic [1:0] RadixBin = 2'd0;
  localparam logic [1:0] RadixOct = 2'd1;
  localparam logic [1:0] RadixDec = 2'd2;
  localparam logic [1:0] RadixHex = 2'd3;

  // Digit value of a byte that is no hex digit at all
  localparam logic [4:0] NoDigit = 5'd16;

  // One classified byte on its way to the back
  typedef struct packed {
    logic       clear;
    logic       is_digit;
    logic [3:0] digit;
    logic [1:0] radix_code;
    logic [7:0] character;
  } rdsb_op_t;

  // Hex value of a text byte, NoDigit for anything else
  function automatic logic [4:0] digit_value(input logic [7:0] ch);
    logic [4:0] dv;
    dv = NoDigit;
    if (ch >= 8'h30 && ch <= 8'h39) dv = 5'(ch - 8'h30);         // '0'..'9'
    else if (ch >= 8'h61 && ch <= 8'h66) dv = 5'(ch - 8'h57);    // 'a'..'f'
    else if (ch >= 8'h41 && ch <= 8'h46) dv = 5'(ch - 8'h37);    // 'A'..'F'
    return dv;
  endfunction

  function automatic logic [4:0] radix_of(input logic [1:0] code);
    logic [4:0] r;
    case (code)
      RadixBin: r = 5'd2;
      RadixOct: r = 5'd8;
      RadixDec: r = 5'd10;
      RadixHex: r = 5'd16;
      default:  r = 5'd2;
    endcase
    return r;
  endfunction

  // Digit count from which the result is taken from the limbs; a decimal value may wrap one digit earlier
  function automatic logic [5:0] limit_of(input logic [1:0] code);
    logic [5:0] l;
    case (code)
      RadixBin: l = 6'd33;
      RadixOct: l = 6'd11;
      RadixDec: l = 6'd11;
      RadixHex: l = 6'd9;
      default:  l = 6'd33;
    endcase
    return l;
  endfunction

endpackage

@@ rtl/rdsb_front.sv @@
// Front end: accepts text bytes, tracks the open numeral and classifies digits.
`timescale 1ns / 1ps

module rdsb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          character,
  input  logic [1:0]          radix_code,
  input  logic                first,
  output logic                push_valid,
  input  logic                push_ready,
  output rdsb_pkg::rdsb_op_t  push_op
);

  logic       open_num;
  logic       open_num_next;
  logic [1:0] cur_code;
  logic [1:0] cur_code_next;
  logic       accept;
  logic       eff_open;
  logic [1:0] eff_code;
  logic [4:0] dv;
  logic       is_digit;

  // Classify the byte against the radix in force for it
  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign eff_open = first || open_num;
  assign eff_code = first ? radix_code : cur_code;
  assign dv       = rdsb_pkg::digit_value(character);
  assign is_digit = dv < rdsb_pkg::radix_of(eff_code);

  // Forward only bytes that belong to a numeral; drop the rest
  assign push_valid         = accept && eff_open;
  assign push_op.clear      = first;
  assign push_op.is_digit   = is_digit;
  assign push_op.digit      = dv[3:0];
  assign push_op.radix_code = eff_code;
  assign push_op.character  = character;

  // A non-digit closes the numeral
  always_comb begin
    open_num_next = open_num;
    cur_code_next = cur_code;
    if (accept) begin
      open_num_next = eff_open && is_digit;
      cur_code_next = eff_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_num <= 1'b0;
      cur_code <= rdsb_pkg::RadixBin;
    end else begin
      open_num <= open_num_next;
      cur_code <= cur_code_next;
    end
  end

endmodule

@@ rtl/rdsb_queue.sv @@
// Short FIFO of classified bytes between front and back.
`timescale 1ns / 1ps

module rdsb_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  rdsb_pkg::rdsb_op_t  push_op,
  output logic                pop_valid,
  input  logic                pop_ready,
  output rdsb_pkg::rdsb_op_t  pop_op
);

  rdsb_pkg::rdsb_op_t               slots [rdsb_pkg::QueueDepth];
  logic [rdsb_pkg::QueuePtrW-1:0]   wr_ptr;
  logic [rdsb_pkg::QueuePtrW-1:0]   rd_ptr;
  logic [rdsb_pkg::QueueCntW-1:0]   fill;
  logic                             do_push;
  logic                             do_pop;

  assign push_ready = fill != rdsb_pkg::QueueCntW'(rdsb_pkg::QueueDepth);
  assign pop_valid  = fill != '0;
  assign pop_op     = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_op;
  end

  // Advance pointers and fill level; pointers wrap at the power-of-two depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ rtl/rdsb_back.sv @@
// Back end: accumulates digits into the small value and the limb memory, emits results.
`timescale 1ns / 1ps

module rdsb_back #(
  parameter int LIMB_COUNT = rdsb_pkg::LimbCountDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  rdsb_pkg::rdsb_op_t  pop_op,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                is_bignum,
  output logic [31:0]         value,
  output logic [3:0]          limb_index,
  output logic [4:0]          limb_count,
  output logic [7:0]          terminator,
  output logic                last
);

  localparam int AW     = $clog2(LIMB_COUNT);
  localparam int LB     = rdsb_pkg::LimbBits;
  localparam int MaxOut = (LIMB_COUNT > rdsb_pkg::MaxResults) ? rdsb_pkg::MaxResults
                                                              : LIMB_COUNT;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LIMB  = 7'b0000010,
    S_GROW  = 7'b0000100,
    S_PAIR0 = 7'b0001000,
    S_PAIR1 = 7'b0010000,
    S_SMALL = 7'b0100000,
    S_BIG   = 7'b1000000
  } state_t;

  // Limb memory
  logic [LB-1:0] mem [LIMB_COUNT];
  logic [LB-1:0] rdata;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [LB-1:0] wr_data;

  // Registers
  state_t        state, state_next;
  logic [31:0]   acc, acc_next;
  logic [5:0]    cnt, cnt_next;
  logic [AW-1:0] top, top_next;
  logic          empty, empty_next;
  logic [1:0]    radix_r, radix_r_next;
  logic [7:0]    term, term_next;
  logic [4:0]    carry, carry_next;
  logic [AW-1:0] idx, idx_next;
  logic [31:0]   small_val, small_val_next;

  logic          out_load;
  logic          out_free;
  logic          ld_big;
  logic [31:0]   ld_value;
  logic [3:0]    ld_index;
  logic [4:0]    ld_count;
  logic          ld_last;

  // Working values
  logic [31:0]   eff_acc;
  logic [5:0]    eff_cnt;
  logic [AW-1:0] eff_top;
  logic          eff_empty;
  logic [4:0]    op_radix;
  logic [4:0]    loop_radix;
  logic [LB-1:0] limb;
  logic [20:0]   work;
  logic [AW:0]   top_inc;
  logic [AW-1:0] last_idx;

  assign pop_ready  = state == S_IDLE;
  assign out_free   = !out_valid || out_ready;
  assign op_radix   = rdsb_pkg::radix_of(pop_op.radix_code);
  assign loop_radix = rdsb_pkg::radix_of(radix_r);
  assign top_inc    = {1'b0, top} + 1'b1;
  assign last_idx   = (top > AW'(MaxOut - 1)) ? AW'(MaxOut - 1) : top;
  assign limb       = empty ? '0 : rdata;
  assign work       = 21'(carry) + 21'(loop_radix) * 21'(limb);

  // Sequence digits, limb passes and result emission
  always_comb begin
    state_next     = state;
    acc_next       = acc;
    cnt_next       = cnt;
    top_next       = top;
    empty_next     = empty;
    radix_r_next   = radix_r;
    term_next      = term;
    carry_next     = carry;
    idx_next       = idx;
    small_val_next = small_val;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = idx;
    wr_data        = work[LB-1:0];
    out_load       = 1'b0;
    ld_big         = 1'b0;
    ld_value       = small_val;
    ld_index       = '0;
    ld_count       = 5'd1;
    ld_last        = 1'b1;
    eff_acc        = pop_op.clear ? '0 : acc;
    eff_cnt        = pop_op.clear ? '0 : cnt;
    eff_top        = pop_op.clear ? '0 : top;
    eff_empty      = pop_op.clear ? 1'b1 : empty;

    case (state)
      S_IDLE: begin
        if (pop_valid) begin
          // Apply the numeral start, then the byte itself
          radix_r_next = pop_op.radix_code;
          term_next    = pop_op.character;
          top_next     = eff_top;
          empty_next   = eff_empty;
          acc_next     = eff_acc;
          cnt_next     = eff_cnt;
          rd_en        = 1'b1;
          rd_addr      = '0;
          idx_next     = '0;
          if (pop_op.is_digit) begin
            acc_next   = 32'(eff_acc * 32'(op_radix)) + 32'(pop_op.digit);
            cnt_next   = (eff_cnt == 6'd63) ? eff_cnt : eff_cnt + 6'd1;
            carry_next = 5'(pop_op.digit);
            state_next = S_LIMB;
          end else if (eff_cnt < rdsb_pkg::limit_of(pop_op.radix_code)) begin
            small_val_next = eff_acc;
            state_next     = S_SMALL;
          end else if (eff_top < AW'(2)) begin
            state_next = S_PAIR0;
          end else begin
            state_next = S_BIG;
          end
        end
      end

      S_LIMB: begin
        // Multiply one limb by the radix and add the running carry
        wr_en      = 1'b1;
        wr_addr    = idx;
        carry_next = work[20:16];
        if (idx == top) begin
          empty_next = 1'b0;
          if (work[20:16] != '0 && top_inc < (AW+1)'(LIMB_COUNT)) begin
            state_next = S_GROW;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          idx_next = idx + 1'b1;
          rd_en    = 1'b1;
          rd_addr  = idx + 1'b1;
        end
      end

      S_GROW: begin
        // Open a new top limb with the leftover carry
        wr_en      = 1'b1;
        wr_addr    = top_inc[AW-1:0];
        wr_data    = LB'(carry);
        top_next   = top_inc[AW-1:0];
        state_next = S_IDLE;
      end

      S_PAIR0: begin
        small_val_next[15:0] = limb;
        rd_en                = 1'b1;
        rd_addr              = AW'(1);
        state_next           = S_PAIR1;
      end

      S_PAIR1: begin
        small_val_next[31:16] = (top >= AW'(1) && !empty) ? rdata : '0;
        state_next            = S_SMALL;
      end

      S_SMALL: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_BIG: begin
        // Send one limb per transfer, lowest first
        if (out_free) begin
          out_load = 1'b1;
          ld_big   = 1'b1;
          ld_value = 32'(rdata);
          ld_index = 4'(idx);
          ld_count = 5'(top_inc);
          ld_last  = idx == last_idx;
          if (idx == last_idx) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx + 1'b1;
            rd_en    = 1'b1;
            rd_addr  = idx + 1'b1;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Limb memory ports
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      acc       <= '0;
      cnt       <= '0;
      top       <= '0;
      empty     <= 1'b1;
      radix_r   <= rdsb_pkg::RadixBin;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      acc       <= acc_next;
      cnt       <= cnt_next;
      top       <= top_next;
      empty     <= empty_next;
      radix_r   <= radix_r_next;
      out_valid <= out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    term      <= term_next;
    carry     <= carry_next;
    idx       <= idx_next;
    small_val <= small_val_next;
    if (out_load) begin
      is_bignum  <= ld_big;
      value      <= ld_value;
      limb_index <= ld_index;
      limb_count <= ld_count;
      terminator <= term;
      last       <= ld_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_limb_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_LIMB |-> idx <= top)
    else $error("limb pass index beyond top limb");

  a_big_has_limbs: assert property (@(posedge clk) disable iff (rst)
    state == S_BIG |-> !empty && top >= AW'(2))
    else $error("bignum emission without three live limbs");

  a_top_bounded: assert property (@(posedge clk) disable iff (rst)
    top_inc <= (AW+1)'(LIMB_COUNT))
    else $error("top limb beyond limb memory");

  a_no_load_when_full: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result loaded over a waiting result");
`endif

endmodule

@@ rtl/radix_digit_string_to_bignum_core.sv @@
// Top level: radix digit string to multi-limb integer converter.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    character, radix_code, first
//   result    out        out_valid / out_ready  is_bignum, value, limb_index,
//                                               limb_count, terminator, last
//
// The front takes one byte per cycle while its two-entry queue has room.
// A digit holds the back while the shared radix multiplier passes over each limb in
// turn through the limb memory port, and while a new top limb takes a leftover carry.
// A terminator gives one small result, or one result transfer per limb sent.
// Reset is synchronous; the limb memory needs no clearing pass (fill tracking).
// A waiting result stalls only the back; the front keeps filling the queue.
`timescale 1ns / 1ps

module radix_digit_string_to_bignum_core #(
  parameter int LIMB_COUNT = rdsb_pkg::LimbCountDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  character,
  input  logic [1:0]  radix_code,
  input  logic        first,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_bignum,
  output logic [31:0] value,
  output logic [3:0]  limb_index,
  output logic [4:0]  limb_count,
  output logic [7:0]  terminator,
  output logic        last
);

  logic               push_valid;
  logic               push_ready;
  rdsb_pkg::rdsb_op_t push_op;
  logic               pop_valid;
  logic               pop_ready;
  rdsb_pkg::rdsb_op_t pop_op;

  rdsb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .character  (character),
    .radix_code (radix_code),
    .first      (first),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  rdsb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  rdsb_back #(
    .LIMB_COUNT (LIMB_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_bignum  (is_bignum),
    .value      (value),
    .limb_index (limb_index),
    .limb_count (limb_count),
    .terminator (terminator),
    .last       (last)
  );

endmodule

@@ verif/radix_digit_string_to_bignum_core_test.sv @@
// Self-checking testbench for the radix digit string to multi-limb integer converter.
`timescale 1ns / 1ps

module radix_digit_string_to_bignum_core_test;

  localparam int NumLimbs   = rdsb_pkg::LimbCountDefault;
  localparam int CycleLimit = 200000;
  localparam int PhaseBytes = 44;
  localparam logic [4:0] NotADigit = 5'd16;

  // One result of a closed numeral, in port order
  typedef struct packed {
    logic        is_bignum;
    logic [31:0] value;
    logic [3:0]  limb_index;
    logic [4:0]  limb_count;
    logic [7:0]  terminator;
    logic        last;
  } numeral_result_t;

  // One directed byte; typed rows carry the small value read off by hand
  typedef struct packed {
    logic [7:0]  character;
    logic [1:0]  radix_code;
    logic        first;
    logic        typed;
    logic [31:0] typed_value;
  } text_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  character = 8'h00;
  logic [1:0]  radix_code = rdsb_pkg::RadixBin;
  logic        first = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        is_bignum;
  logic [31:0] value;
  logic [3:0]  limb_index;
  logic [4:0]  limb_count;
  logic [7:0]  terminator;
  logic        last;

  // Numeral state of the predictor
  logic [31:0] wrapped_value = '0;
  int          digits_seen = 0;
  logic [15:0] limb_words [NumLimbs];
  int          top_word = 0;
  logic [1:0]  numeral_radix_code = rdsb_pkg::RadixBin;
  logic        numeral_open = 1'b0;

  numeral_result_t step_results [rdsb_pkg::MaxResults];
  int              step_count;
  numeral_result_t expected_results [$];
  text_row_t       directed_rows [$];

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int bytes_sent = 0;
  int noise_bytes = 0;
  int results_checked = 0;
  int limb_results = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  radix_digit_string_to_bignum_core #(
    .LIMB_COUNT(NumLimbs)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .character (character),
    .radix_code(radix_code),
    .first     (first),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_bignum (is_bignum),
    .value     (value),
    .limb_index(limb_index),
    .limb_count(limb_count),
    .terminator(terminator),
    .last      (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [4:0] radix_value(input logic [1:0] code);
    case (code)
      rdsb_pkg::RadixBin: return 5'd2;
      rdsb_pkg::RadixOct: return 5'd8;
      rdsb_pkg::RadixDec: return 5'd10;
      default:            return 5'd16;
    endcase
  endfunction

  // Digit count from which the limbs are used; a decimal 32-bit value may wrap one digit earlier
  function automatic int wrap_limit(input logic [1:0] code);
    case (code)
      rdsb_pkg::RadixBin: return 33;
      rdsb_pkg::RadixOct: return 11;
      rdsb_pkg::RadixDec: return 11;
      default:            return 9;
    endcase
  endfunction

  function automatic logic [4:0] hex_digit_of(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return 5'(ch - "0");
    if (ch >= "a" && ch <= "f") return 5'(ch - "a" + 10);
    if (ch >= "A" && ch <= "F") return 5'(ch - "A" + 10);
    return NotADigit;
  endfunction

  function automatic numeral_result_t small_result(input logic [31:0] v,
                                                   input logic [7:0] term);
    numeral_result_t r;
    r.is_bignum  = 1'b0;
    r.value      = v;
    r.limb_index = '0;
    r.limb_count = 5'd1;
    r.terminator = term;
    r.last       = 1'b1;
    return r;
  endfunction

  // Advance the numeral state by one byte and list the results it closes with
  function automatic void convert_byte(input logic [7:0] ch, input logic [1:0] code,
                                       input logic fst);
    logic [4:0]  radix;
    logic [4:0]  dv;
    logic [31:0] work;
    logic [31:0] carry;
    int          i;
    step_count = 0;
    if (fst) begin
      wrapped_value = '0;
      digits_seen = 0;
      for (i = 0; i < NumLimbs; i++) limb_words[i] = '0;
      top_word = 0;
      numeral_radix_code = code;
      numeral_open = 1'b1;
    end
    if (!numeral_open) return;
    radix = radix_value(numeral_radix_code);
    dv = hex_digit_of(ch);
    if (dv < radix) begin
      wrapped_value = wrapped_value * 32'(radix) + 32'(dv);
      if (digits_seen < 63) digits_seen++;
      carry = 32'(dv);
      for (i = 0; i <= top_word && i < NumLimbs; i++) begin
        work = carry + 32'(radix) * 32'(limb_words[i]);
        limb_words[i] = work[15:0];
        carry = work >> rdsb_pkg::LimbBits;
      end
      // grow while room is left, else drop the carry
      if (carry != 0 && top_word + 1 < NumLimbs) begin
        top_word++;
        limb_words[top_word] = carry[15:0];
      end
      return;
    end
    numeral_open = 1'b0;
    if (digits_seen < wrap_limit(numeral_radix_code)) begin
      step_results[0] = small_result(wrapped_value, ch);
      step_count = 1;
    end else if (top_word < 2) begin
      step_results[0] = small_result({limb_words[1], limb_words[0]}, ch);
      step_count = 1;
    end else begin
      step_count = (top_word + 1 > rdsb_pkg::MaxResults) ? rdsb_pkg::MaxResults
                                                         : top_word + 1;
      for (i = 0; i < step_count; i++) begin
        step_results[i].is_bignum  = 1'b1;
        step_results[i].value      = {16'h0000, limb_words[i]};
        step_results[i].limb_index = 4'(i);
        step_results[i].limb_count = 5'(top_word + 1);
        step_results[i].terminator = ch;
        step_results[i].last       = (i + 1 == step_count);
      end
    end
  endfunction

  // Offer one byte, hold it until the transfer, then queue what it produces
  task automatic send_byte(input logic [7:0] ch, input logic [1:0] code, input logic fst,
                           input logic typed, input logic [31:0] typed_value);
    int i;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    character  <= ch;
    radix_code <= code;
    first      <= fst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    convert_byte(ch, code, fst);
    if (typed) expected_results.push_back(small_result(typed_value, ch));
    else for (i = 0; i < step_count; i++) expected_results.push_back(step_results[i]);
    bytes_sent++;
  endtask

  // Stray bytes at times, then one numeral with random digits; sometimes left open for a restart
  task automatic send_random_numeral(input logic force_overflow);
    logic [1:0] code;
    logic [4:0] radix;
    logic [3:0] dv;
    logic [7:0] ch;
    logic [7:0] term;
    int         lim;
    int         ndig;
    int         sel;
    int         k;
    code = force_overflow ? rdsb_pkg::RadixHex : 2'($urandom_range(0, 3));
    radix = radix_value(code);
    lim = wrap_limit(code);
    sel = $urandom_range(0, 19);
    if (force_overflow) ndig = $urandom_range(65, 70);
    else if (sel < 10) ndig = $urandom_range(0, lim - 1);
    else if (sel < 15) ndig = $urandom_range(lim, lim + 6);
    else if (sel < 18) ndig = lim + $urandom_range(0, 2);
    else ndig = $urandom_range(18, 30);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_byte(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)), 1'b0, 1'b0, '0);
        noise_bytes++;
      end
    end
    for (k = 0; k < ndig; k++) begin
      dv = 4'($urandom_range(0, radix - 1));
      // leading zeros keep a long numeral within two limbs
      if (!force_overflow && sel >= 15 && sel < 18 && k < ndig - lim + 2) dv = '0;
      ch = (dv < 10) ? 8'h30 + 8'(dv)
                     : ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(dv) - 8'd10;
      send_byte(ch, (k == 0) ? code : 2'($urandom_range(0, 3)), k == 0, 1'b0, '0);
    end
    if (force_overflow || $urandom_range(0, 9) != 0) begin
      do term = 8'($urandom_range(0, 255)); while (hex_digit_of(term) < radix);
      send_byte(term, (ndig == 0) ? code : 2'($urandom_range(0, 3)), ndig == 0, 1'b0, '0);
    end
  endtask

  task automatic report_result_error(input string why, input numeral_result_t want,
                                     input numeral_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] %s: expected big=%0d value=%h idx=%0d cnt=%0d term=%h last=%0d",
               $realtime, why, want.is_bignum, want.value, want.limb_index,
               want.limb_count, want.terminator, want.last);
      $display("          got      big=%0d value=%h idx=%0d cnt=%0d term=%h last=%0d",
               got.is_bignum, got.value, got.limb_index, got.limb_count,
               got.terminator, got.last);
    end
  endtask

  // Check each result transfer against the oldest expectation, then pick the next stall
  always @(posedge clk) begin : result_check
    numeral_result_t got;
    numeral_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.is_bignum  = is_bignum;
        got.value      = value;
        got.limb_index = limb_index;
        got.limb_count = limb_count;
        got.terminator = terminator;
        got.last       = last;
        results_checked++;
        if (is_bignum) limb_results++;
        if (expected_results.size() == 0) begin
          report_result_error("result with nothing expected", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) report_result_error("result mismatch", want, got);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // Hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("** radix_digit_string_to_bignum_core: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int p;
    int random_start;
    // closed numeral: ignored
    directed_rows.push_back({"x", rdsb_pkg::RadixHex, 1'b0, 1'b0, 32'd0});
    // non-digit opening byte: empty numeral
    directed_rows.push_back({" ", rdsb_pkg::RadixBin, 1'b1, 1'b1, 32'd0});
    // largest value that still fits, mixed case
    directed_rows.push_back({"F", rdsb_pkg::RadixHex, 1'b1, 1'b0, 32'd0});
    directed_rows.push_back({"f", rdsb_pkg::RadixBin, 1'b0, 1'b0, 32'd0});
    directed_rows.push_back({"F", rdsb_pkg::RadixOct, 1'b0, 1'b0, 32'd0});
    directed_rows.push_back({"f", rdsb_pkg::RadixDec, 1'b0, 1'b0, 32'd0});
    directed_rows.push_back({"F", rdsb_pkg::RadixBin, 1'b0, 1'b0, 32'd0});
    directed_rows.push_back({"F", rdsb_pkg::RadixBin, 1'b0, 1'b0, 32'd0});
    directed_rows.push_back({"f", rdsb_pkg::RadixBin, 1'b0, 1'b0, 32'd0});
    directed_rows.push_back({"F", rdsb_pkg::RadixBin, 1'b0, 1'b0, 32'd0});
    directed_rows.push_back({";", rdsb_pkg::RadixHex, 1'b0, 1'b1, 32'hFFFF_FFFF});
    // restart drops the decimal numeral
    directed_rows.push_back({"1", rdsb_pkg::RadixDec, 1'b1, 1'b0, 32'd0});
    directed_rows.push_back({"2", rdsb_pkg::RadixDec, 1'b0, 1'b0, 32'd0});
    directed_rows.push_back({"a", rdsb_pkg::RadixHex, 1'b1, 1'b0, 32'd0});
    directed_rows.push_back({"F", rdsb_pkg::RadixBin, 1'b0, 1'b0, 32'd0});
    directed_rows.push_back({8'h00, rdsb_pkg::RadixBin, 1'b0, 1'b1, 32'h0000_00AF});
    // digit at the radix ends binary and octal numerals
    directed_rows.push_back({"1", rdsb_pkg::RadixBin, 1'b1, 1'b0, 32'd0});
    directed_rows.push_back({"2", rdsb_pkg::RadixBin, 1'b0, 1'b1, 32'd1});
    directed_rows.push_back({"7", rdsb_pkg::RadixOct, 1'b1, 1'b0, 32'd0});
    directed_rows.push_back({"8", rdsb_pkg::RadixOct, 1'b0, 1'b1, 32'd7});
    // top byte value as an empty numeral
    directed_rows.push_back({8'hFF, rdsb_pkg::RadixDec, 1'b1, 1'b1, 32'd0});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    sender_idle_pct = 17;
    receiver_idle_pct = 69;
    foreach (directed_rows[i])
      send_byte(directed_rows[i].character, directed_rows[i].radix_code,
                directed_rows[i].first, directed_rows[i].typed, directed_rows[i].typed_value);

    random_start = bytes_sent;
    for (p = 0; p < 3; p++) begin
      sender_idle_pct   = (p == 0) ? 17 : (p == 1) ? 69 : 0;
      receiver_idle_pct = (p == 0) ? 69 : (p == 1) ? 17 : 0;
      // one numeral long enough to overflow every limb
      if (p == 1) send_random_numeral(1'b1);
      while (bytes_sent - noise_bytes - random_start < PhaseBytes * (p + 1))
        send_random_numeral(1'b0);
    end
    in_valid <= 1'b0;

    // drain, then watch for stray results
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d text bytes (%0d stray), checked %0d results of which %0d were limbs.",
             bytes_sent, noise_bytes, results_checked, limb_results);
    $display("Covered all four radixes, empty and restarted numerals, two-limb and overflowing "
             , "bignums under three stall mixes.");
    if (mismatch_count == 0) begin
      $display("** radix_digit_string_to_bignum_core: PASSED **");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("** radix_digit_string_to_bignum_core: FAILED **");
    end
    $finish;
  end

endmodule
